/* hdl/dmts_pkg.sv */
// ----------------------------------------------------------------------------
// dmts_pkg
// Shared types, constants, font ROM and helpers for the dot matrix text
// scanner.
// ----------------------------------------------------------------------------
package dmts_pkg;

  // Geometry
  localparam int GLYPH_ROWS    = 8;
  localparam int NUM_MODULES   = 4;
  localparam int IDX_W         = 5;
  localparam int MAX_WR_DEPTH  = 2 ** IDX_W;
  localparam int MSG_DEPTH_DEF = 32;
  localparam int LEN_W         = 7;
  localparam int CFG_AW        = 5;

  // Characters and column patterns
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_C     = 8'h43;
  localparam logic [7:0] CHAR_FIRST = 8'h20;
  localparam logic [7:0] CHAR_LAST  = 8'h7E;
  localparam logic [7:0] COL_BLANK  = 8'hFF;

  // Commands
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Display modes
  localparam logic [2:0] MODE_FIXED  = 3'd0;
  localparam logic [2:0] MODE_BLINK  = 3'd1;
  localparam logic [2:0] MODE_SCROLL = 3'd2;
  localparam logic [2:0] MODE_CLOCK  = 3'd3;
  localparam logic [2:0] MODE_TEMP   = 3'd4;

  // Register indexes
  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_FRAMES = 3'd1;
  localparam logic [2:0] REG_LENGTH = 3'd2;
  localparam logic [2:0] REG_VHIGH  = 3'd3;
  localparam logic [2:0] REG_VLOW   = 3'd4;

  // Register reset values
  localparam logic [15:0] FRAMES_RST = 16'd100;
  localparam logic [5:0]  LENGTH_RST = 6'd4;

  typedef struct packed {
    logic       command;
    logic [4:0] char_index;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0] row_enable;
    logic [7:0] column_0;
    logic [7:0] column_1;
    logic [7:0] column_2;
    logic [7:0] column_3;
    logic       period_done;
  } out_item_t;

  typedef logic [NUM_MODULES-1:0][7:0] char4_t;

  // Message store controls from the scan sequencer
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [7:0]       wr_code;
    logic             advance;
    logic             wrap;
  } store_ctrl_t;

  // Font for codes 32..126, row 0 in the top byte
  localparam logic [63:0] FONT_ROM [95] = '{
    64'hFFFFFFFFFFFFFFFF, 64'hE7C3C3E7E7FFE7FF, 64'h999999FFFFFFFFFF,
    64'hC9C980C980C9C9FF, 64'hF7C1F5C1D7C1F7FF, 64'hFF9CCCE7F3999CFF,
    64'hE3C9E391C4CC91FF, 64'hE7E7F3FFFFFFFFFF, 64'hCFE7F3F3F3E7CFFF,
    64'hF3E7CFCFCFE7F3FF, 64'hFF99C380C399FFFF, 64'hFFE7E781E7E7FFFF,
    64'hFFFFFFFFE7E7F3FF, 64'hFFFFFF80FFFFFFFF, 64'hFFFFFFFFFFF3F3FF,
    64'h9FCFE7F3F9FCFEFF, 64'hC19C8C849098C1FF, 64'hE7E3E7E7E7E781FF,
    64'hC3999FC7F39981FF, 64'hC3999FC79F99C3FF, 64'hC7C3C9CC80CF87FF,
    64'h81F9C19F9F99C3FF, 64'hC7F3F9C19999C3FF, 64'h81999FCFE7E7E7FF,
    64'hC39999C39999C3FF, 64'hC39999839FCFE3FF, 64'hFFF3F3FFFFF3F3FF,
    64'hF3F3FFFFF3F3F9FF, 64'hE7F3F9FCF9F3E7FF, 64'hFFFF80FFFF80FFFF,
    64'hF9F3E7CFE7F3F9FF, 64'hE1CCCFE7F3FFF3FF, 64'hC19C848484FCE1FF,
    64'hE7C39999819999FF, 64'hC09999C19999C0FF, 64'hC399FCFCFC99C3FF,
    64'hE0C9999999C9E0FF, 64'h80B9E9E1E9B980FF, 64'h80B9E9E1E9F9F0FF,
    64'hC399FCFC8C9981FF, 64'h99999981999999FF, 64'hC3E7E7E7E7E7C3FF,
    64'h87CFCFCFCCCCE1FF, 64'h9899C9E1C99998FF, 64'hF0F9F9F9B99980FF,
    64'h9C888080949C9CFF, 64'h9C9890848C9C9CFF, 64'hE3C99C9C9CC9E3FF,
    64'hC09999C1F9F9F0FF, 64'hC399999989C38FFF, 64'hC09999C1899998FF,
    64'hC399F1E38F99C3FF, 64'h81A5E7E7E7E7C3FF, 64'h999999999999C3FF,
    64'h9999999999C3E7FF, 64'h9C9C9C9480889CFF, 64'h9CC9E3F7E3C99CFF,
    64'h999999C3E7E7C3FF, 64'h809CCEE7B39980FF, 64'hE1F9F9F9F9F9E1FF,
    64'hFCF9F3E7CF9FBFFF, 64'hE1E7E7E7E7E7E1FF, 64'hF7E3C99CFFFFFFFF,
    64'hFFFFFFFFFFFFFF80, 64'hF3F3E7FFFFFFFFFF, 64'hFFFFE1CFC1CC91FF,
    64'hF8F9F9C19999C4FF, 64'hFFFFE1CCFCCCE1FF, 64'hC7CFCFC1CCCC91FF,
    64'hFFFFE1CCC0FCE1FF, 64'hE3C9F9F0F9F9F0FF, 64'hFFFFE1CCCCC0CFE1,
    64'hF8F9C991999998FF, 64'hF3FFF1F3F3F3E1FF, 64'hCFFFCFCFCFCCCCE1,
    64'hF8F999C9E1C998FF, 64'hF1F3F3F3F3F3E1FF, 64'hFFFFC98080949CFF,
    64'hFFFFE0CCCCCCCCFF, 64'hFFFFE1CCCCCCE1FF, 64'hFFFFC19999C1F9F1,
    64'hFFFF91CCCCC1CF87, 64'hFFFFC49199F9F0FF, 64'hFFFFC1FCE1CFE0FF,
    64'hF7F3C1F3F3D3E7FF, 64'hFFFFCCCCCCCC91FF, 64'hFFFFCCCCCCE1F3FF,
    64'hFFFF9C948080C9FF, 64'hFFFF9CC9E3C99CFF, 64'hFFFFCCCCCCC0CFE7,
    64'hFFFFC0E6F3D9C0FF, 64'hC7F3F3F8F3F3C7FF, 64'hE7E7E7FFE7E7E7FF,
    64'hF8F3F3C7F3F3F8FF, 64'h91C4FFFFFFFFFFFF
  };

  localparam logic [63:0] DEG_GLYPH = 64'hE3DDDDE3FFFFFFFF;

  // Pick one row byte out of a packed glyph
  function automatic logic [7:0] row_byte(input logic [63:0] g, input logic [2:0] row);
    logic [2:0] rr;
    rr = ~row;
    return g[{rr, 3'b000} +: 8];
  endfunction

  // Font lookup; codes outside the font show blank
  function automatic logic [7:0] glyph_row(input logic [7:0] code, input logic [2:0] row);
    logic [7:0] ofs;
    ofs = code - CHAR_FIRST;
    if (code < CHAR_FIRST || code > CHAR_LAST) begin
      return COL_BLANK;
    end
    return row_byte(FONT_ROM[ofs[6:0]], row);
  endfunction

  // Clamp a two-digit value
  function automatic logic [6:0] sat99(input logic [6:0] v);
    return (v > 7'd99) ? 7'd99 : v;
  endfunction

  // Tens digit of a value up to 99: multiply by 205/2048
  function automatic logic [3:0] tens_of(input logic [6:0] v);
    logic [14:0] prod;
    prod = 15'(v) * 15'd205;
    return prod[14:11];
  endfunction

  function automatic logic [3:0] ones_of(input logic [6:0] v);
    logic [6:0] t10;
    t10 = 7'(tens_of(v)) * 7'd10;
    return 4'(v - t10);
  endfunction

endpackage

/* hdl/dmts_msg_store.sv */
// ----------------------------------------------------------------------------
// dmts_msg_store
// Message store with a shadow copy of the four-character scroll window and
// one registered lookahead read for the next character to slide in.
// ----------------------------------------------------------------------------
module dmts_msg_store
  import dmts_pkg::*;
#(
  parameter int MSG_DEPTH = MSG_DEPTH_DEF,
  parameter int POS_W     = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  store_ctrl_t      ctrl,
  input  logic [POS_W-1:0] pos,
  output char4_t           head,
  output char4_t           window
);

  // Only the first MAX_WR_DEPTH entries can ever be written
  localparam int STORE_DEPTH = (MSG_DEPTH < MAX_WR_DEPTH) ? MSG_DEPTH : MAX_WR_DEPTH;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int AX_W        = (POS_W + 2 > IDX_W) ? POS_W + 2 : IDX_W;

  logic [7:0]             mem_r [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] vld_r;
  logic [7:0]             fix_ch [NUM_MODULES+1];
  logic [AX_W-1:0]        widx_x;
  logic [AX_W-1:0]        pos_x;
  logic [AX_W-1:0]        rd_addr;
  logic                   wr_ok;
  logic                   rd_hit;
  logic [7:0]             rd_data_r;
  char4_t                 win_r, win_nxt;
  logic [7:0]             look_r, look_nxt;

  assign widx_x  = AX_W'(ctrl.wr_idx);
  assign pos_x   = AX_W'(pos);
  assign rd_addr = pos_x + AX_W'(NUM_MODULES + 1);
  assign wr_ok   = ctrl.wr_en && (widx_x < AX_W'(STORE_DEPTH));
  assign rd_hit  = rd_addr < AX_W'(STORE_DEPTH);

  // Write the store
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem_r[widx_x[AW-1:0]] <= ctrl.wr_code;
    end
  end

  // Mark written entries; unwritten ones read as space
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_ok) begin
      vld_r[widx_x[AW-1:0]] <= 1'b1;
    end
  end

  // Prefetch the character one past the lookahead slot, forwarding a write
  always_ff @(posedge clk) begin
    if (!rd_hit) begin
      rd_data_r <= CHAR_SPACE;
    end else if (wr_ok && widx_x == rd_addr) begin
      rd_data_r <= ctrl.wr_code;
    end else if (vld_r[rd_addr[AW-1:0]]) begin
      rd_data_r <= mem_r[rd_addr[AW-1:0]];
    end else begin
      rd_data_r <= CHAR_SPACE;
    end
  end

  // Fixed taps at the head of the message
  for (genvar g = 0; g <= NUM_MODULES; g++) begin : g_fix
    if (g < STORE_DEPTH) begin : g_in
      assign fix_ch[g] = vld_r[g] ? mem_r[g] : CHAR_SPACE;
    end else begin : g_out
      assign fix_ch[g] = CHAR_SPACE;
    end
  end

  for (genvar g = 0; g < NUM_MODULES; g++) begin : g_head
    assign head[g] = fix_ch[g];
  end

  // Keep the window shadow in step with the store and the scroll position
  always_comb begin
    win_nxt  = win_r;
    look_nxt = look_r;
    if (ctrl.wrap) begin
      for (int k = 0; k < NUM_MODULES; k++) begin
        win_nxt[k] = fix_ch[k];
      end
      look_nxt = fix_ch[NUM_MODULES];
    end else if (ctrl.advance) begin
      for (int k = 0; k < NUM_MODULES - 1; k++) begin
        win_nxt[k] = win_r[k+1];
      end
      win_nxt[NUM_MODULES-1] = look_r;
      look_nxt               = rd_data_r;
    end else if (wr_ok) begin
      for (int k = 0; k < NUM_MODULES; k++) begin
        if (widx_x == pos_x + AX_W'(k)) begin
          win_nxt[k] = ctrl.wr_code;
        end
      end
      if (widx_x == pos_x + AX_W'(NUM_MODULES)) begin
        look_nxt = ctrl.wr_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= {NUM_MODULES{CHAR_SPACE}};
      look_r <= CHAR_SPACE;
    end else begin
      win_r  <= win_nxt;
      look_r <= look_nxt;
    end
  end

  assign window = win_r;

endmodule

/* hdl/dot_matrix_text_scanner_top.sv */
// ----------------------------------------------------------------------------
// dot_matrix_text_scanner_top
// Row-scan driver for four 8x8 LED modules with fixed, blink, scroll, clock
// and temperature display modes.
// ----------------------------------------------------------------------------
// Takes one item per clock unless in_stall is high. An accepted item lands in an
// input register; a tick then goes through the font lookup, digit split and
// counter update in one combinational pass into the output register, from
// which its row shows on out_data. A write updates the message store on
// leaving the input register and gives no result. in_stall rises only while
// a tick waits in the input register and the output register is full and
// stalled. The store comes out of reset as all spaces with no clearing pass.
module dot_matrix_text_scanner_top
  import dmts_pkg::*;
#(
  parameter int MSG_DEPTH = MSG_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int LEN_CAP = (MSG_DEPTH < 63) ? MSG_DEPTH : 63;
  localparam int POS_W   = $clog2(LEN_CAP);

  // Configuration registers
  logic [2:0]  mode_r;
  logic [15:0] fps_r;
  logic [5:0]  mlen_r;
  logic [6:0]  vhi_r;
  logic [6:0]  vlo_r;
  logic        cfg_wr;
  logic [2:0]  reg_idx;

  // Input register and output register
  logic        s1_valid_r;
  in_item_t    s1_item_r;
  logic        s1_is_tick;
  logic        s1_fire;
  logic        tick_fire;
  logic        out_load_ok;
  logic        out_valid_r;
  out_item_t   out_data_r;
  out_item_t   out_nxt;

  // Scan state
  logic [2:0]       row_r;
  logic [15:0]      frame_r;
  logic [POS_W-1:0] pos_r;
  logic             blank_r;

  logic [15:0]      limit;
  logic [LEN_W-1:0] eff_len;
  logic             frame_end;
  logic             period_end;
  logic             scroll_last;
  logic             done;

  store_ctrl_t ctrl;
  char4_t      head;
  char4_t      window;
  logic [7:0]  col [NUM_MODULES];
  logic [6:0]  hi_sat;
  logic [6:0]  lo_sat;
  logic [7:0]  hi_t, hi_o, lo_t, lo_o;
  logic [7:0]  scroll_ch;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_FIXED;
      fps_r  <= FRAMES_RST;
      mlen_r <= LENGTH_RST;
      vhi_r  <= '0;
      vlo_r  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MODE:   mode_r <= pwdata[2:0];
        REG_FRAMES: fps_r  <= pwdata[15:0];
        REG_LENGTH: mlen_r <= pwdata[5:0];
        REG_VHIGH:  vhi_r  <= pwdata[6:0];
        REG_VLOW:   vlo_r  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:   prdata = 32'(mode_r);
      REG_FRAMES: prdata = 32'(fps_r);
      REG_LENGTH: prdata = 32'(mlen_r);
      REG_VHIGH:  prdata = 32'(vhi_r);
      REG_VLOW:   prdata = 32'(vlo_r);
      default:    prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  assign out_load_ok = !out_valid_r || !out_stall;
  assign s1_is_tick  = s1_item_r.command == CMD_TICK;
  assign s1_fire     = s1_valid_r && (!s1_is_tick || out_load_ok);
  assign tick_fire   = s1_fire && s1_is_tick;
  assign in_stall    = s1_valid_r && !s1_fire;

  // Capture the incoming item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_data;
    end
  end

  // ---------------- period timing ----------------
  assign limit     = (fps_r == '0) ? 16'd1 : fps_r;
  assign frame_end = row_r == 3'(GLYPH_ROWS - 1);
  assign period_end = frame_end && ((17'(frame_r) + 17'd1) >= 17'(limit));

  always_comb begin
    if (mlen_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (9'(mlen_r) > 9'(MSG_DEPTH)) begin
      eff_len = LEN_W'(MSG_DEPTH);
    end else begin
      eff_len = LEN_W'(mlen_r);
    end
  end

  assign scroll_last = (LEN_W'(pos_r) + LEN_W'(1)) >= eff_len;

  always_comb begin
    done = 1'b0;
    if (period_end) begin
      if (mode_r == MODE_BLINK) begin
        done = blank_r;
      end else if (mode_r == MODE_SCROLL) begin
        done = scroll_last;
      end else begin
        done = 1'b1;
      end
    end
  end

  // Advance the row, frame, blink and scroll state on each tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= '0;
      frame_r <= '0;
      pos_r   <= '0;
      blank_r <= 1'b0;
    end else if (tick_fire) begin
      row_r <= row_r + 3'd1;
      if (period_end) begin
        frame_r <= '0;
        if (mode_r == MODE_BLINK) begin
          blank_r <= !blank_r;
        end else if (mode_r == MODE_SCROLL) begin
          pos_r <= scroll_last ? '0 : pos_r + POS_W'(1);
        end
      end else if (frame_end) begin
        frame_r <= frame_r + 16'd1;
      end
    end
  end

  // ---------------- message store ----------------
  assign ctrl.wr_en   = s1_fire && !s1_is_tick;
  assign ctrl.wr_idx  = s1_item_r.char_index;
  assign ctrl.wr_code = s1_item_r.char_code;
  assign ctrl.advance = tick_fire && period_end && (mode_r == MODE_SCROLL) && !scroll_last;
  assign ctrl.wrap    = tick_fire && period_end && (mode_r == MODE_SCROLL) && scroll_last;

  dmts_msg_store #(
    .MSG_DEPTH (MSG_DEPTH),
    .POS_W     (POS_W)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .pos    (pos_r),
    .head   (head),
    .window (window)
  );

  // ---------------- row rendering ----------------
  assign hi_sat = sat99(vhi_r);
  assign lo_sat = sat99(vlo_r);
  assign hi_t   = CHAR_ZERO + 8'(tens_of(hi_sat));
  assign hi_o   = CHAR_ZERO + 8'(ones_of(hi_sat));
  assign lo_t   = CHAR_ZERO + 8'(tens_of(lo_sat));
  assign lo_o   = CHAR_ZERO + 8'(ones_of(lo_sat));

  always_comb begin
    scroll_ch = CHAR_SPACE;
    for (int k = 0; k < NUM_MODULES; k++) begin
      col[k] = COL_BLANK;
    end
    unique case (mode_r)
      MODE_FIXED: begin
        for (int k = 0; k < NUM_MODULES; k++) begin
          col[k] = glyph_row(head[k], row_r);
        end
      end
      MODE_BLINK: begin
        for (int k = 0; k < NUM_MODULES; k++) begin
          col[k] = blank_r ? COL_BLANK : glyph_row(head[k], row_r);
        end
      end
      MODE_SCROLL: begin
        // Positions past the message show spaces
        for (int k = 0; k < NUM_MODULES; k++) begin
          scroll_ch = ((LEN_W'(pos_r) + LEN_W'(k)) < eff_len) ? window[k] : CHAR_SPACE;
          col[k]    = glyph_row(scroll_ch, row_r);
        end
      end
      MODE_CLOCK: begin
        col[0] = glyph_row(hi_t, row_r);
        col[1] = glyph_row(hi_o, row_r);
        col[2] = glyph_row(lo_t, row_r);
        col[3] = glyph_row(lo_o, row_r);
      end
      MODE_TEMP: begin
        col[0] = glyph_row(hi_t, row_r);
        col[1] = glyph_row(hi_o, row_r);
        col[2] = row_byte(DEG_GLYPH, row_r);
        col[3] = glyph_row(CHAR_C, row_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    out_nxt.row_enable  = 8'b1 << row_r;
    out_nxt.column_0    = col[0];
    out_nxt.column_1    = col[1];
    out_nxt.column_2    = col[2];
    out_nxt.column_3    = col[3];
    out_nxt.period_done = done;
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tick_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hdl/dmts_checker.sv */
// ----------------------------------------------------------------------------
// dmts_checker
// Port-level checks for the dot matrix text scanner, bound to the top level.
// ----------------------------------------------------------------------------
module dmts_checker
  import dmts_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // Hold a stalled item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result item changed or dropped");

  // Drive exactly one row per result
  a_row_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot(out_data.row_enable))
    else $error("row enable is not one-hot");

  // End a period only on the last row of a frame
  a_done_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.period_done |-> out_data.row_enable[GLYPH_ROWS-1])
    else $error("period done outside the last row");

  // Stall the input only behind a full, stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the output can move");

endmodule

bind dot_matrix_text_scanner_top dmts_checker u_dmts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
